[rtl/urav_pkg.sv]
`timescale 1ns / 1ps

package urav_pkg;

  // Field widths of the ports.
  localparam int TIME_W    = 16;
  localparam int DIST_W    = 9;
  localparam int LEVEL_W   = 3;
  localparam int PERIOD_W  = 14;
  localparam int DUTY_W    = 13;
  localparam int DIGIT_W   = 4;
  localparam int COUNT_W   = 2;
  localparam int PRESET_W  = 9;
  localparam int SELECT_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 9;

  // Block constants.
  localparam int WINDOW_LEN   = 10;
  localparam int TICKS_PER_CM = 58;
  localparam int MAX_RANGE_CM = 400;
  localparam int NUM_PRESETS  = 5;

  localparam int SAMPLE_W   = 11;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int SUM_W      = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);

  // Division by a constant as multiply by a rounded-up reciprocal and shift.
  // With shift = N + ceil(log2(d)), the quotient is exact for any N-bit value.
  localparam int TPC_L      = $clog2(TICKS_PER_CM);
  localparam int TPC_SHIFT  = TIME_W + TPC_L;
  localparam int TPC_MUL_W  = TIME_W + 1;
  localparam int TPC_MUL    = (1 << TPC_SHIFT) / TICKS_PER_CM + 1;

  localparam int WIN_L      = $clog2(WINDOW_LEN);
  localparam int WIN_SHIFT  = SUM_W + WIN_L;
  localparam int WIN_MUL_W  = SUM_W + 1;
  localparam int WIN_MUL    = (1 << WIN_SHIFT) / WINDOW_LEN + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_1      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_SELECT = 3'd5;

  typedef logic [NUM_PRESETS-1:0][PRESET_W-1:0] preset_arr_t;

  localparam preset_arr_t PRESET_RESET = {9'd220, 9'd100, 9'd60, 9'd25, 9'd5};

  typedef struct packed {
    logic [DIST_W-1:0]   distance_cm;
    logic [LEVEL_W-1:0]  tone_level;
    logic [PERIOD_W-1:0] pwm_period;
    logic [DUTY_W-1:0]   pwm_duty;
    logic [DIGIT_W-1:0]  digit_ones;
    logic [DIGIT_W-1:0]  digit_tens;
    logic [DIGIT_W-1:0]  digit_hundreds;
    logic [COUNT_W-1:0]  digit_count;
  } result_t;

endpackage

[rtl/urav_window.sv]
`timescale 1ns / 1ps

module urav_window
  import urav_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]    sum
);

  logic [SAMPLE_W-1:0] window [WINDOW_LEN];
  logic [SUM_W-1:0]    sum_next;

  // The running sum adds the incoming sample and drops the oldest one.
  assign sum_next = sum + SUM_W'(sample) - SUM_W'(window[WINDOW_LEN-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
    end else if (shift) begin
      sum       <= sum_next;
      window[0] <= sample;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

endmodule

[rtl/urav_result.sv]
`timescale 1ns / 1ps

module urav_result
  import urav_pkg::*;
(
  input  logic [DIST_W-1:0]   avg_cm,
  input  preset_arr_t         presets,
  input  logic [SELECT_W-1:0] preset_select,
  output result_t             result
);

  // avg_cm / 10 and avg_cm / 100 by reciprocal, exact for any 9-bit value.
  localparam int DIV10_MUL    = 205;
  localparam int DIV10_SHIFT  = 11;
  localparam int DIV100_MUL   = 41;
  localparam int DIV100_SHIFT = 12;
  localparam int P10_W        = DIST_W + 8;
  localparam int P100_W       = DIST_W + 6;

  localparam logic [PERIOD_W-1:0] PERIOD_TAB [6] =
    '{14'd0, 14'd12134, 14'd3405, 14'd2272, 14'd1516, 14'd1136};
  localparam logic [DUTY_W-1:0] DUTY_TAB [6] =
    '{13'd0, 13'd6067, 13'd1702, 13'd1136, 13'd758, 13'd568};

  logic [P10_W-1:0]   prod10;
  logic [P100_W-1:0]  prod100;
  logic [DIST_W-1:0]  quot10;
  logic [DIST_W-1:0]  quot100;
  logic               sel_match;
  logic [LEVEL_W-1:0] level;

  always_comb begin
    sel_match = 1'b0;
    for (int i = 0; i < NUM_PRESETS; i++) begin
      if (32'(preset_select) == i) begin
        sel_match = (presets[i] == avg_cm);
      end
    end
    // If the selected preset matches, the first match sets the level, selected or not.
    level = '0;
    if (sel_match) begin
      for (int i = NUM_PRESETS - 1; i >= 0; i--) begin
        if (presets[i] == avg_cm) begin
          level = LEVEL_W'(NUM_PRESETS - i);
        end
      end
    end
  end

  assign prod10  = P10_W'(avg_cm) * P10_W'(DIV10_MUL);
  assign prod100 = P100_W'(avg_cm) * P100_W'(DIV100_MUL);
  assign quot10  = DIST_W'(prod10 >> DIV10_SHIFT);
  assign quot100 = DIST_W'(prod100 >> DIV100_SHIFT);

  always_comb begin
    result.distance_cm    = avg_cm;
    result.tone_level     = level;
    result.pwm_period     = '0;
    result.pwm_duty       = '0;
    case (level)
      3'd1, 3'd2, 3'd3, 3'd4, 3'd5: begin
        result.pwm_period = PERIOD_TAB[level];
        result.pwm_duty   = DUTY_TAB[level];
      end
      default: begin
        result.pwm_period = '0;
        result.pwm_duty   = '0;
      end
    endcase
    result.digit_ones     = DIGIT_W'(avg_cm - DIST_W'(quot10 * DIST_W'(10)));
    result.digit_tens     = DIGIT_W'(quot10 - DIST_W'(quot100 * DIST_W'(10)));
    result.digit_hundreds = DIGIT_W'(quot100);
    if (avg_cm > DIST_W'(99)) begin
      result.digit_count = 2'd3;
    end else if (avg_cm > DIST_W'(9)) begin
      result.digit_count = 2'd2;
    end else begin
      result.digit_count = 2'd1;
    end
  end

endmodule

[rtl/ultrasonic_range_averager.sv]
`timescale 1ns / 1ps
// Pipeline: a word passes through five registered stages, from the ticks register to the result.
// Throughput: one word per cycle while out_ready is high; a stage holding an untaken word stalls
// the stages behind it, so words keep entering a stalled pipeline only until its empty stages fill.
// Reset: synchronous; empties the pipeline, zeroes the ten-sample window and its sum,
// and loads the preset registers with their default distances.
module ultrasonic_range_averager
  import urav_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TIME_W-1:0]    echo_ticks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DIST_W-1:0]    distance_cm,
  output logic [LEVEL_W-1:0]   tone_level,
  output logic [PERIOD_W-1:0]  pwm_period,
  output logic [DUTY_W-1:0]    pwm_duty,
  output logic [DIGIT_W-1:0]   digit_ones,
  output logic [DIGIT_W-1:0]   digit_tens,
  output logic [DIGIT_W-1:0]   digit_hundreds,
  output logic [COUNT_W-1:0]   digit_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int TPC_PROD_W = TIME_W + TPC_MUL_W;
  localparam int TPC_QUOT_W = TPC_PROD_W - TPC_SHIFT;
  localparam int WIN_PROD_W = SUM_W + WIN_MUL_W;
  localparam int WIN_QUOT_W = WIN_PROD_W - WIN_SHIFT;

  // Configuration registers.
  preset_arr_t         presets;
  logic [SELECT_W-1:0] preset_select;

  // Pipeline registers.
  logic                v1, v2, v3, v4, v5;
  logic [TIME_W-1:0]   ticks;
  logic [SAMPLE_W-1:0] sample;
  logic [SUM_W-1:0]    sum;
  logic [DIST_W-1:0]   avg_cm;
  result_t             res;

  logic                load2, load3, load4, load5;
  logic [TPC_PROD_W-1:0] tpc_prod;
  logic [TPC_QUOT_W-1:0] tpc_quot;
  logic [SAMPLE_W-1:0]   sample_next;
  logic [WIN_PROD_W-1:0] win_prod;
  logic [WIN_QUOT_W-1:0] win_quot;
  logic [DIST_W-1:0]     avg_cm_next;
  result_t               res_next;

  // A stage loads when the one before holds a word and it is empty or emptying.
  assign load5    = v4 && (!v5 || out_ready);
  assign load4    = v3 && (!v4 || load5);
  assign load3    = v2 && (!v3 || load4);
  assign load2    = v1 && (!v2 || load3);
  assign in_ready = !v1 || load2;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      presets       <= PRESET_RESET;
      preset_select <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < NUM_PRESETS; i++) begin
        if (cfg_index == CFG_PRESET_1 + CFG_IDX_W'(i)) begin
          presets[i] <= PRESET_W'(cfg_data);
        end
      end
      if (cfg_index == CFG_PRESET_SELECT) begin
        preset_select <= cfg_data[SELECT_W-1:0];
      end
    end
  end

  // Stage 2: ticks to centimetres, clamped to the window's sample width.
  assign tpc_prod = TPC_PROD_W'(ticks) * TPC_PROD_W'(TPC_MUL);
  assign tpc_quot = tpc_prod[TPC_PROD_W-1:TPC_SHIFT];
  assign sample_next = (32'(tpc_quot) > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX)
                                                    : SAMPLE_W'(tpc_quot);

  // Stage 3: window and running sum.
  urav_window u_window (
    .clk    (clk),
    .rst    (rst),
    .shift  (load3),
    .sample (sample),
    .sum    (sum)
  );

  // Stage 4: average, saturated at the maximum range.
  assign win_prod    = WIN_PROD_W'(sum) * WIN_PROD_W'(WIN_MUL);
  assign win_quot    = win_prod[WIN_PROD_W-1:WIN_SHIFT];
  assign avg_cm_next = (32'(win_quot) > MAX_RANGE_CM) ? DIST_W'(MAX_RANGE_CM)
                                                      : DIST_W'(win_quot);

  // Stage 5: level, tone and digits.
  urav_result u_result (
    .avg_cm        (avg_cm),
    .presets       (presets),
    .preset_select (preset_select),
    .result        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= (in_valid && in_ready) || (v1 && !load2);
      v2 <= load2 || (v2 && !load3);
      v3 <= load3 || (v3 && !load4);
      v4 <= load4 || (v4 && !load5);
      v5 <= load5 || (v5 && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ticks <= echo_ticks;
    end
    if (load2) begin
      sample <= sample_next;
    end
    if (load4) begin
      avg_cm <= avg_cm_next;
    end
    if (load5) begin
      res <= res_next;
    end
  end

  assign out_valid      = v5;
  assign distance_cm    = res.distance_cm;
  assign tone_level     = res.tone_level;
  assign pwm_period     = res.pwm_period;
  assign pwm_duty       = res.pwm_duty;
  assign digit_ones     = res.digit_ones;
  assign digit_tens     = res.digit_tens;
  assign digit_hundreds = res.digit_hundreds;
  assign digit_count    = res.digit_count;

`ifndef SYNTHESIS
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (32'(avg_cm) <= MAX_RANGE_CM))
    else $error("averaged distance above maximum range");

  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !load5) |=> (v4 && $stable(avg_cm)))
    else $error("stalled distance stage lost its word");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (32'(res.digit_hundreds) * 100 + 32'(res.digit_tens) * 10
            + 32'(res.digit_ones) == 32'(res.distance_cm)))
    else $error("decimal digits do not rebuild the distance");

  a_silent: assert property (@(posedge clk) disable iff (rst)
    (v5 && res.tone_level == '0) |-> (res.pwm_period == '0 && res.pwm_duty == '0))
    else $error("tone active at level zero");
`endif

endmodule

[tb/tb_ultrasonic_range_averager.sv]
`timescale 1ns / 1ps

module tb_ultrasonic_range_averager;
  import urav_pkg::*;

  localparam int CYCLE_LIMIT  = 50000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 40;

  // Indexes past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_PRESET_SELECT + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_PRESET_SELECT + 3'd2;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    echo_ticks = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DIST_W-1:0]    distance_cm;
  logic [LEVEL_W-1:0]   tone_level;
  logic [PERIOD_W-1:0]  pwm_period;
  logic [DUTY_W-1:0]    pwm_duty;
  logic [DIGIT_W-1:0]   digit_ones;
  logic [DIGIT_W-1:0]   digit_tens;
  logic [DIGIT_W-1:0]   digit_hundreds;
  logic [COUNT_W-1:0]   digit_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  ultrasonic_range_averager uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .echo_ticks(echo_ticks),
    .out_valid(out_valid), .out_ready(out_ready),
    .distance_cm(distance_cm), .tone_level(tone_level),
    .pwm_period(pwm_period), .pwm_duty(pwm_duty),
    .digit_ones(digit_ones), .digit_tens(digit_tens),
    .digit_hundreds(digit_hundreds), .digit_count(digit_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the block state used to predict each result word.
  logic [SAMPLE_W-1:0] echo_window [WINDOW_LEN];
  logic [PRESET_W-1:0] pred_preset [NUM_PRESETS];
  logic [SELECT_W-1:0] pred_select;

  logic [TIME_W-1:0] echo_backlog [$];
  result_t           expected_ranges [$];
  int                echoes_issued = 0;
  int                ranges_checked = 0;
  int                mismatches = 0;
  int                cycle_count = 0;
  bit                in_fire = 1'b0;
  bit                out_fire = 1'b0;
  bit                no_idle = 1'b0;
  int                send_gap = 0;
  int                recv_wait = 0;

  function automatic logic [PERIOD_W-1:0] tone_period(input int lvl);
    case (lvl)
      1: tone_period = 14'd12134;
      2: tone_period = 14'd3405;
      3: tone_period = 14'd2272;
      4: tone_period = 14'd1516;
      5: tone_period = 14'd1136;
      default: tone_period = '0;
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] tone_duty(input int lvl);
    case (lvl)
      1: tone_duty = 13'd6067;
      2: tone_duty = 13'd1702;
      3: tone_duty = 13'd1136;
      4: tone_duty = 13'd758;
      5: tone_duty = 13'd568;
      default: tone_duty = '0;
    endcase
  endfunction

  task automatic average_echo(input logic [TIME_W-1:0] ticks, output result_t r);
    int sample;
    int sum;
    int avg;
    int lvl;
    sample = ticks / TICKS_PER_CM;
    if (sample > SAMPLE_MAX) sample = SAMPLE_MAX;
    for (int i = WINDOW_LEN - 1; i > 0; i--) echo_window[i] = echo_window[i-1];
    echo_window[0] = sample[SAMPLE_W-1:0];
    sum = 0;
    for (int i = 0; i < WINDOW_LEN; i++) sum += int'(echo_window[i]);
    avg = sum / WINDOW_LEN;
    if (avg > MAX_RANGE_CM) avg = MAX_RANGE_CM;
    // The selected preset gates the tone, but the level comes from the
    // lowest-numbered preset holding the same distance.
    lvl = 0;
    if (pred_select < NUM_PRESETS && pred_preset[pred_select] == avg) begin
      for (int i = NUM_PRESETS - 1; i >= 0; i--) begin
        if (pred_preset[i] == avg) lvl = NUM_PRESETS - i;
      end
    end
    r.distance_cm    = avg[DIST_W-1:0];
    r.tone_level     = lvl[LEVEL_W-1:0];
    r.pwm_period     = tone_period(lvl);
    r.pwm_duty       = tone_duty(lvl);
    r.digit_ones     = DIGIT_W'(avg % 10);
    r.digit_tens     = DIGIT_W'((avg / 10) % 10);
    r.digit_hundreds = DIGIT_W'((avg / 100) % 10);
    r.digit_count    = (avg > 99) ? 2'd3 : ((avg > 9) ? 2'd2 : 2'd1);
  endtask

  task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DAT_W-1:0] data);
    if (idx < CFG_PRESET_1 + NUM_PRESETS) pred_preset[idx - CFG_PRESET_1] = data;
    else if (idx == CFG_PRESET_SELECT) pred_select = data[SELECT_W-1:0];
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: samples every handshake at the rising edge.
  always @(posedge clk) begin : monitor
    result_t fresh;
    result_t want;
    cycle_count <= cycle_count + 1;
    in_fire  = !rst && in_valid && in_ready;
    out_fire = !rst && out_valid && out_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
      if (out_fire) begin
        if (expected_ranges.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result word, expected none, actual distance %0d",
                     $time, distance_cm);
        end else begin
          want = expected_ranges.pop_front();
          compare_field("distance_cm", want.distance_cm, distance_cm);
          compare_field("tone_level", want.tone_level, tone_level);
          compare_field("pwm_period", want.pwm_period, pwm_period);
          compare_field("pwm_duty", want.pwm_duty, pwm_duty);
          compare_field("digit_ones", want.digit_ones, digit_ones);
          compare_field("digit_tens", want.digit_tens, digit_tens);
          compare_field("digit_hundreds", want.digit_hundreds, digit_hundreds);
          compare_field("digit_count", want.digit_count, digit_count);
          ranges_checked++;
        end
      end
      if (in_fire) begin
        average_echo(echo_ticks, fresh);
        expected_ranges.push_back(fresh);
      end
    end
  end

  // Driver: moves the input and result handshakes at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      echo_ticks <= '0;
      out_ready  <= 1'b0;
    end else begin
      if (!(in_valid && !in_fire)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (echo_backlog.size() > 0) begin
          in_valid   <= 1'b1;
          echo_ticks <= echo_backlog.pop_front();
          send_gap = no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_fire) recv_wait = no_idle ? 0 : $urandom_range(0, 3);
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_echo(input int ticks);
    echo_backlog.push_back(ticks[TIME_W-1:0]);
    echoes_issued++;
  endtask

  // Mostly runs of one distance long enough to fill the window, most of them on a
  // preset so the average lands on it; short broken runs and raw noise in between.
  task automatic queue_echo_runs(input int n);
    int queued;
    int mode;
    int run_len;
    int target;
    queued = 0;
    while (queued < n) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        if (mode < 3 && pred_select < NUM_PRESETS) target = int'(pred_preset[pred_select]);
        else if (mode < 5) target = int'(pred_preset[$urandom_range(0, NUM_PRESETS - 1)]);
        else target = $urandom_range(0, MAX_RANGE_CM);
        run_len = $urandom_range(10, 14);
        repeat (run_len) queue_echo(target * TICKS_PER_CM + $urandom_range(0, TICKS_PER_CM - 1));
      end else if (mode < 9) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) queue_echo($urandom_range(0, (MAX_RANGE_CM + 1) * TICKS_PER_CM));
      end else begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) queue_echo($urandom_range(0, 65535));
      end
      queued += run_len;
    end
  endtask

  // Holds the stimulus until every queued word has come back.
  task automatic wait_idle();
    do @(negedge clk); while (ranges_checked != echoes_issued);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ultrasonic_range_averager test failed");
    $finish;
  end

  initial begin
    int pick;
    int sel;
    logic [CFG_DAT_W-1:0] data;
    for (int i = 0; i < WINDOW_LEN; i++) echo_window[i] = '0;
    for (int i = 0; i < NUM_PRESETS; i++) pred_preset[i] = PRESET_RESET[i];
    pred_select = '0;

    // Directed words: field extremes and bit patterns while the window is
    // still filling, then a settled run on the first default preset and a
    // run that drives the average into saturation.
    queue_echo(0);
    queue_echo(65535);
    queue_echo(TICKS_PER_CM - 1);
    queue_echo(TICKS_PER_CM);
    queue_echo(TICKS_PER_CM + 1);
    queue_echo(16'h5555);
    queue_echo(16'hAAAA);
    queue_echo(16'h00FF);
    queue_echo(16'hFF00);
    repeat (10) queue_echo(PRESET_RESET[0] * TICKS_PER_CM);
    repeat (6) queue_echo(65535);
    repeat (4) @(negedge clk);
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    queue_echo_runs(80);
    wait_idle();

    // Extreme presets: zero twice, full range, one out of reach.
    write_setting(CFG_PRESET_1, 9'd0);
    write_setting(CFG_PRESET_1 + 3'd1, 9'd400);
    write_setting(CFG_PRESET_1 + 3'd2, 9'h1FF);
    write_setting(CFG_PRESET_1 + 3'd3, 9'd0);
    write_setting(CFG_PRESET_1 + 3'd4, 9'd257);
    write_setting(CFG_PRESET_SELECT, 9'h1FB);
    queue_echo_runs(70);
    wait_idle();

    // Select values past the last preset, and writes to unused indexes.
    write_setting(CFG_PRESET_SELECT, 9'd7);
    write_setting(CFG_SPARE_A, 9'h1FF);
    write_setting(CFG_SPARE_B, 9'h155);
    no_idle = 1'b1;
    queue_echo_runs(50);
    wait_idle();
    write_setting(CFG_PRESET_SELECT, 9'd5);
    no_idle = 1'b0;

    repeat (3) begin
      wait_idle();
      for (int i = 0; i < NUM_PRESETS; i++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0 && i > 0) data = pred_preset[$urandom_range(0, i - 1)];
        else if (pick == 1) data = CFG_DAT_W'($urandom_range(MAX_RANGE_CM + 1, 511));
        else data = CFG_DAT_W'($urandom_range(0, MAX_RANGE_CM));
        write_setting(CFG_PRESET_1 + CFG_IDX_W'(i), data);
      end
      sel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
      write_setting(CFG_PRESET_SELECT, CFG_DAT_W'(($urandom_range(0, 63) << 3) | sel));
      no_idle = ($urandom_range(0, 2) == 0);
      queue_echo_runs(60);
    end

    wait_idle();
    if (mismatches == 0 && expected_ranges.size() == 0) begin
      $display("ultrasonic_range_averager test passed");
    end else begin
      $display("ultrasonic_range_averager test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/urav_pkg.sv
rtl/urav_window.sv
rtl/urav_result.sv
rtl/ultrasonic_range_averager.sv
tb/tb_ultrasonic_range_averager.sv
